/* rtl/tmbn_pkg.sv */
package tmbn_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VERT_W       = $clog2(MAX_VERTICES);
	localparam int COUNT_W      = $clog2(MAX_VERTICES + 1);

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_BOUND   = 2'd2,
		FUNC_NEAREST = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_WEIGHT  = 2'd0,
		KIND_BOUND   = 2'd1,
		KIND_NEAREST = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_WAIT,
		ST_COL_SCAN,
		ST_ROW_SCAN,
		ST_SORT,
		ST_SUM,
		ST_NEAR_SCAN,
		ST_OUT
	} state_t;

	localparam logic signed [31:0] NO_EDGE_Q8 = -32'sd256;
	localparam logic signed [39:0] BOUND_MAX  = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] BOUND_MIN  = 40'sh80_0000_0000;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic [31:0] weight;
		logic [39:0] bound;
		logic [3:0]  vertex;
	} result_t;

endpackage

/* rtl/tmbn_ram.sv */
module tmbn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/tmbn_core.sv */
module tmbn_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            func,
	input  logic [3:0]            row_vertex,
	input  logic [3:0]            col_vertex,
	input  logic [31:0]           weight_in,
	input  logic [15:0]           visited_mask,
	input  logic [tmbn_pkg::COUNT_W-1:0] n,
	output logic                  busy,
	output tmbn_pkg::result_t     res,
	input  logic                  res_take
);
	import tmbn_pkg::*;

	localparam int VW = VERT_W;
	localparam int NW = COUNT_W;
	localparam int AW = 2 * VW;

	state_t state_q, state_d;
	logic [VW-1:0] i_q, j_q;
	logic [NW-1:0] k_q;
	logic [1:0] func_q;
	logic [15:0] mask_q;
	logic signed [31:0] acc_q;
	logic have_q, pend_q;
	logic [VW-1:0] pos_q;
	logic [VW-1:0] pi_q, pj_q;
	logic signed [31:0] cmax_q [MAX_VERTICES];
	logic signed [31:0] rmax_q [MAX_VERTICES];
	logic signed [39:0] sum_q;
	logic [NW-1:0] pass_q;
	logic valid_q;
	logic [1:0] kind_q;
	logic [31:0] weight_q;
	logic [39:0] bound_q;
	logic [3:0] vertex_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic signed [31:0] rdata;
	logic row_ok, col_ok;

	assign row_ok = {{(NW > 4 ? NW-4 : 0){1'b0}}, row_vertex} < n;
	assign col_ok = {{(NW > 4 ? NW-4 : 0){1'b0}}, col_vertex} < n;
	assign we = start && func == FUNC_WRITE && row_ok && col_ok;
	assign waddr = {row_vertex[VW-1:0], col_vertex[VW-1:0]};

	tmbn_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES * MAX_VERTICES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(weight_in),
		.raddr(raddr), .rdata(rdata)
	);

	logic [NW-1:0] nm1, half_c, half_r;
	logic last_j, last_i;
	logic signed [31:0] sa, sb;
	logic signed [39:0] addend, wide;
	logic vis;

	assign nm1 = n - NW'(1);
	assign half_c = n >> 1;
	assign half_r = (n >> 1) + {{(NW-1){1'b0}}, n[0]};
	assign last_j = {1'b0, pj_q} == nm1;
	assign last_i = {1'b0, pi_q} == nm1;
	assign vis = (pj_q < 16) ? mask_q[4'(pj_q)] : 1'b0;
	assign busy = state_q != ST_IDLE;
	assign res = {valid_q, kind_q, weight_q, bound_q, vertex_q};

	always_comb begin
		raddr = {i_q, j_q};
		if (state_q == ST_COL_SCAN) begin
			raddr = {j_q, i_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT) begin
				valid_q <= 1'b1;
			end else if (res_take) begin
				valid_q <= 1'b0;
			end
			if (state_q == ST_COL_SCAN || state_q == ST_ROW_SCAN || state_q == ST_NEAR_SCAN) begin
				pend_q <= 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (func_t'(func))
						FUNC_WRITE:   state_d = ST_IDLE;
						FUNC_READ:    state_d = ST_RD_ADDR;
						FUNC_BOUND:   state_d = ST_COL_SCAN;
						FUNC_NEAREST: state_d = row_ok ? ST_NEAR_SCAN : ST_OUT;
					endcase
				end
			end
			ST_RD_ADDR:   state_d = ST_RD_WAIT;
			ST_RD_WAIT:   state_d = ST_OUT;
			ST_COL_SCAN:  if (pend_q && last_i && last_j) state_d = ST_ROW_SCAN;
			ST_ROW_SCAN:  if (pend_q && last_i && last_j) state_d = ST_SORT;
			ST_SORT:      if (pass_q == n) state_d = ST_SUM;
			ST_SUM:       if (k_q == n) state_d = ST_OUT;
			ST_NEAR_SCAN: if (pend_q && last_j) state_d = ST_OUT;
			ST_OUT:       state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		sa = (k_q < half_c) ? cmax_q[k_q[VW-1:0]] : 32'sd0;
		sb = (k_q < half_r) ? rmax_q[k_q[VW-1:0]] : 32'sd0;
		addend = 40'(sa) + 40'(sb);
		wide = sum_q + addend;
	end

	always_ff @(posedge clk) begin
		pi_q <= i_q;
		pj_q <= j_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_q <= func;
					mask_q <= visited_mask;
					i_q <= (func == FUNC_NEAREST || func == FUNC_READ) ? row_vertex[VW-1:0] : '0;
					j_q <= (func == FUNC_READ) ? col_vertex[VW-1:0] : '0;
					have_q <= 1'b0;
					pos_q <= '0;
					acc_q <= '0;
					pass_q <= '0;
					k_q <= '0;
					sum_q <= '0;
					bound_q <= '0;
					vertex_q <= '0;
					weight_q <= '0;
					kind_q <= KIND_WEIGHT;
					if (func == FUNC_READ && !(row_ok && col_ok)) begin
						i_q <= '0;
						j_q <= '0;
					end
					if (func == FUNC_READ) have_q <= row_ok && col_ok;
				end
			end
			ST_RD_WAIT: begin
				kind_q <= KIND_WEIGHT;
				weight_q <= (have_q && !rdata[31]) ? rdata : NO_EDGE_Q8;
			end
			ST_COL_SCAN, ST_ROW_SCAN: begin
				if (!(pend_q && last_i && last_j)) begin
					if ({1'b0, j_q} == nm1) begin
						j_q <= '0;
						i_q <= i_q + VW'(1);
					end else begin
						j_q <= j_q + VW'(1);
					end
				end else begin
					i_q <= '0;
					j_q <= '0;
				end
				if (pend_q) begin
					if (state_q == ST_COL_SCAN) begin
						if (pi_q != pj_q && rdata > (pj_q == 0 ? 32'sd0 : acc_q)) begin
							acc_q <= rdata;
						end else if (pj_q == 0) begin
							acc_q <= 32'sd0;
						end
						if (last_j) begin
							cmax_q[pi_q] <= (pi_q != pj_q && rdata > (pj_q == 0 ? 32'sd0 : acc_q))
								? rdata : (pj_q == 0 ? 32'sd0 : acc_q);
							have_q <= 1'b0;
						end
					end else begin
						if (pi_q != pj_q && (!(have_q && pj_q != 0) || rdata > acc_q)) begin
							acc_q <= rdata;
							have_q <= 1'b1;
						end else if (pj_q == 0) begin
							have_q <= 1'b0;
						end
						if (last_j) begin
							rmax_q[pi_q] <= (pi_q != pj_q &&
								(!(have_q && pj_q != 0) || rdata > acc_q)) ? rdata :
								((have_q && pj_q != 0) ? acc_q : 32'sd0);
							have_q <= 1'b0;
						end
					end
				end
			end
			ST_SORT: begin
				// odd-even transposition, one compare-swap pair per cycle
				if ({1'b0, j_q} + NW'(1) < n && j_q[0] == pass_q[0]) begin
					if (cmax_q[j_q] > cmax_q[j_q + VW'(1)]) begin
						cmax_q[j_q] <= cmax_q[j_q + VW'(1)];
						cmax_q[j_q + VW'(1)] <= cmax_q[j_q];
					end
					if (rmax_q[j_q] > rmax_q[j_q + VW'(1)]) begin
						rmax_q[j_q] <= rmax_q[j_q + VW'(1)];
						rmax_q[j_q + VW'(1)] <= rmax_q[j_q];
					end
				end
				if ({1'b0, j_q} >= nm1) begin
					j_q <= '0;
					pass_q <= pass_q + NW'(1);
				end else begin
					j_q <= j_q + VW'(1);
				end
			end
			ST_SUM: begin
				k_q <= k_q + NW'(1);
				sum_q <= wide;
				if (k_q == n) begin
					kind_q <= KIND_BOUND;
					bound_q <= sum_q;
				end
			end
			ST_NEAR_SCAN: begin
				if (!(pend_q && last_j)) j_q <= j_q + VW'(1);
				if (pend_q && !vis && (!have_q || rdata < acc_q)) begin
					acc_q <= rdata;
					pos_q <= pj_q;
					have_q <= 1'b1;
				end
				if (pend_q && last_j) begin
					vertex_q <= 4'((!vis && (!have_q || rdata < acc_q)) ? pj_q : pos_q);
				end
			end
			ST_OUT: begin
				if (func_q == FUNC_NEAREST) kind_q <= KIND_NEAREST;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/tsp_matrix_bound_and_nearest_unit.sv */
// Weight matrix unit with bound and nearest-vertex queries.
// Input stream s_axis: one operation per transfer (write, read, bound, nearest),
// the operation code on tuser.
// Output stream m_axis: one result per read, bound or nearest; writes give none.
// The result kind travels on tuser.
// Config channel cfg: sets the vertex count N (clamped to 2..MAX_VERTICES);
// cfg_ready is low while an operation is in progress.
// Write gives no result and leaves the input ready again the next cycle; read
// passes through its address and wait states; nearest scans the row (straight
// to the result when the row is out of range); bound takes longest, set by the
// single RAM read port scanning every entry twice and the one compare-swap
// step per cycle sort.
// s_axis_tready is low while an operation is in progress or a result waits,
// so the next operation is taken the cycle after the result transfer.
// A stalled m_axis holds its result and blocks new operations until taken.
// Reset clears control and sets N to 16; matrix contents are undefined
// until written.
module tsp_matrix_bound_and_nearest_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// row_vertex[3:0], col_vertex[7:4], weight_in[39:8], visited_mask[55:40]
	input  logic [55:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// weight_out[31:0], bound_value[71:32], nearest_vertex[75:72]
	output logic [79:0] m_axis_tdata,
	// result_kind[1:0]
	output logic [1:0]  m_axis_tuser
);
	import tmbn_pkg::*;

	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [4:0] vc_q;
	logic [NW-1:0] n;
	logic busy, start;
	result_t res;

	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= cfg_data;
		end
	end

	always_comb begin
		if (vc_q < 5'd2) begin
			n = NW'(2);
		end else if (32'(vc_q) > MAX_VERTICES) begin
			n = NW'(MAX_VERTICES);
		end else begin
			n = NW'(vc_q);
		end
	end

	assign s_axis_tready = !busy && !res.valid;
	assign start = s_axis_tvalid && s_axis_tready;

	tmbn_core u_core (
		.clk(clk), .arst_n(arst_n), .start(start),
		.func(s_axis_tuser), .row_vertex(s_axis_tdata[3:0]),
		.col_vertex(s_axis_tdata[7:4]), .weight_in(s_axis_tdata[39:8]),
		.visited_mask(s_axis_tdata[55:40]), .n(n),
		.busy(busy), .res(res), .res_take(m_axis_tready)
	);

	assign m_axis_tvalid = res.valid;
	assign m_axis_tdata = {4'b0000, res.vertex, res.bound, res.weight};
	assign m_axis_tuser = res.kind;
endmodule
